@@ rtl/core/dbm_pkg.sv @@
package dbm_pkg;

    localparam int COORD_BITS      = 32;
    localparam int WEIGHT_SUM_BITS = 32;
    localparam int FIELD_BITS      = 16;
    localparam int BORDER_BITS     = COORD_BITS + 3;
    localparam int OUT_BITS        = COORD_BITS + 1;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [BORDER_BITS-1:0] border_t;
    typedef logic [FIELD_BITS-1:0]         field_t;
    typedef logic [WEIGHT_SUM_BITS-1:0]    weight_sum_t;

    localparam border_t BORDER_MAX = {1'b0, {(BORDER_BITS-1){1'b1}}};
    localparam border_t BORDER_MIN = {1'b1, {(BORDER_BITS-1){1'b0}}};

    // one classified anchor as it travels through the queue
    typedef struct packed {
        border_t sum_lo;
        border_t diff_lo;
        border_t diff_hi;
        border_t sum_hi;
        field_t  weight;
        field_t  contig;
        logic    last;
    } anchor_t;

    // queue status seen by its two sides
    typedef struct packed {
        logic rd_valid;
        logic wr_ready;
    } queue_stat_t;

endpackage

@@ rtl/core/diagonal_band_merge_core.sv @@
// diagonal band merge core
//
// input channel (s_*): one alignment anchor per transaction, given by start
// column and row, width, length, weight and contig number; s_last_in_group
// closes the group. result channel (m_*): one enclosing band per group,
// sent only for the transaction that carried s_last_in_group.
//
// throughput: one anchor per cycle while the queue has a free entry. the front
// rotates each anchor into its four diagonal borders and writes it into a
// 4-entry queue; the back pops one entry per cycle, unless its result stages
// are full, into the running min/max and weight sum. a closing anchor passes
// the queue, then the snapshot, parity rounding and output registers, before
// its result shows on m_*.
//
// when the receiver stalls, the back keeps folding anchors until its three
// result stages are full, then holds; the queue fills and s_ready drops once
// it has 4 entries; nothing is lost or repeated.
// reset (aresetn low, synchronous) empties the queue, drops m_valid and
// returns the group state to no anchor seen.
module diagonal_band_merge_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // anchor transactions
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [dbm_pkg::COORD_BITS-1:0] s_pos_x,
    input  logic signed [dbm_pkg::COORD_BITS-1:0] s_pos_y,
    input  logic [dbm_pkg::FIELD_BITS-1:0]        s_band_width,
    input  logic [dbm_pkg::FIELD_BITS-1:0]        s_band_length,
    input  logic [dbm_pkg::FIELD_BITS-1:0]        s_score_weight,
    input  logic [dbm_pkg::FIELD_BITS-1:0]        s_contig_id,
    input  logic                                  s_last_in_group,
    // merged band transactions
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dbm_pkg::OUT_BITS-1:0]   m_merged_x,
    output logic signed [dbm_pkg::OUT_BITS-1:0]   m_merged_y,
    output logic [dbm_pkg::OUT_BITS-1:0]          m_merged_width,
    output logic [dbm_pkg::OUT_BITS-1:0]          m_merged_length,
    output logic [dbm_pkg::WEIGHT_SUM_BITS-1:0]   m_merged_weight,
    output logic [dbm_pkg::FIELD_BITS-1:0]        m_merged_contig
);
    import dbm_pkg::*;

    anchor_t     front_anchor, queue_anchor;
    queue_stat_t q_stat;
    logic        q_pop;

    // classification: borders are formed straight off the input ports
    dbm_front u_front (
        .pos_x         (s_pos_x),
        .pos_y         (s_pos_y),
        .band_width    (s_band_width),
        .band_length   (s_band_length),
        .score_weight  (s_score_weight),
        .contig_id     (s_contig_id),
        .last_in_group (s_last_in_group),
        .anchor        (front_anchor)
    );

    // decoupling queue, accepts whenever it has a free entry
    assign s_ready = q_stat.wr_ready;

    dbm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_valid),
        .wr_data (front_anchor),
        .pop     (q_pop),
        .rd_data (queue_anchor),
        .stat    (q_stat)
    );

    // accumulate, round and emit
    dbm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .anchor        (queue_anchor),
        .q_stat        (q_stat),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .merged_x      (m_merged_x),
        .merged_y      (m_merged_y),
        .merged_width  (m_merged_width),
        .merged_length (m_merged_length),
        .merged_weight (m_merged_weight),
        .merged_contig (m_merged_contig)
    );

endmodule

@@ rtl/core/dbm_front.sv @@
module dbm_front (
    input  logic signed [dbm_pkg::COORD_BITS-1:0] pos_x,
    input  logic signed [dbm_pkg::COORD_BITS-1:0] pos_y,
    input  logic [dbm_pkg::FIELD_BITS-1:0]        band_width,
    input  logic [dbm_pkg::FIELD_BITS-1:0]        band_length,
    input  logic [dbm_pkg::FIELD_BITS-1:0]        score_weight,
    input  logic [dbm_pkg::FIELD_BITS-1:0]        contig_id,
    input  logic                                  last_in_group,
    output dbm_pkg::anchor_t                      anchor
);
    import dbm_pkg::*;

    border_t x_ext, y_ext, w_ext, l_ext, sum_b, diff_b;

    // rotate the anchor into sum and difference diagonals
    always_comb begin
        x_ext  = border_t'(pos_x);
        y_ext  = border_t'(pos_y);
        w_ext  = $signed({{(BORDER_BITS-FIELD_BITS){1'b0}}, band_width});
        l_ext  = $signed({{(BORDER_BITS-FIELD_BITS){1'b0}}, band_length});
        sum_b  = x_ext + y_ext;
        diff_b = x_ext - y_ext;
        anchor.sum_lo  = sum_b;
        anchor.diff_lo = diff_b;
        anchor.diff_hi = diff_b + ((w_ext - border_t'(1)) <<< 1);
        anchor.sum_hi  = sum_b + ((l_ext - border_t'(1)) <<< 1);
        anchor.weight  = score_weight;
        anchor.contig  = contig_id;
        anchor.last    = last_in_group;
    end

endmodule

@@ rtl/core/dbm_queue.sv @@
module dbm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  dbm_pkg::anchor_t      wr_data,
    input  logic                  pop,
    output dbm_pkg::anchor_t      rd_data,
    output dbm_pkg::queue_stat_t  stat
);
    import dbm_pkg::*;

    anchor_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wptr_reg, rptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic                      do_push, do_pop;

    assign stat.rd_valid = (count_reg != '0);
    assign stat.wr_ready = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign do_push       = push && stat.wr_ready;
    assign do_pop        = pop && stat.rd_valid;
    assign rd_data       = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ rtl/core/dbm_back.sv @@
module dbm_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dbm_pkg::anchor_t                      anchor,
    input  dbm_pkg::queue_stat_t                  q_stat,
    output logic                                  pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dbm_pkg::OUT_BITS-1:0]   merged_x,
    output logic signed [dbm_pkg::OUT_BITS-1:0]   merged_y,
    output logic [dbm_pkg::OUT_BITS-1:0]          merged_width,
    output logic [dbm_pkg::OUT_BITS-1:0]          merged_length,
    output logic [dbm_pkg::WEIGHT_SUM_BITS-1:0]   merged_weight,
    output logic [dbm_pkg::FIELD_BITS-1:0]        merged_contig
);
    import dbm_pkg::*;

    localparam int ADJ_BITS  = BORDER_BITS + 1;
    localparam int WIDE_BITS = BORDER_BITS + 2;

    typedef logic signed [ADJ_BITS-1:0]  adj_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;

    // running group state
    border_t     smin_reg, dmin_reg, dmax_reg, smax_reg;
    border_t     smin_next, dmin_next, dmax_next, smax_next;
    weight_sum_t weight_reg, weight_next;
    field_t      contig_reg, contig_next;
    logic        open_reg;
    logic [WEIGHT_SUM_BITS:0] weight_add;

    // stage 1: snapshot of the closed group
    logic        snap_valid_reg;
    border_t     snap_smin_reg, snap_dmin_reg, snap_dmax_reg, snap_smax_reg;
    weight_sum_t snap_weight_reg;
    field_t      snap_contig_reg;

    // stage 2: borders rounded to even spans
    logic        adj_valid_reg;
    adj_t        adj_sminp_reg, adj_dmin_reg, adj_dmaxp2_reg, adj_smaxp2_reg;
    weight_sum_t adj_weight_reg;
    field_t      adj_contig_reg;
    logic        odd_lo, odd_dhi, odd_shi;

    // stage 3: output register
    logic        out_valid_reg;
    logic signed [OUT_BITS-1:0] out_x_reg, out_y_reg;
    logic [OUT_BITS-1:0]        out_w_reg, out_l_reg;
    weight_sum_t out_weight_reg;
    field_t      out_contig_reg;
    wide_t       sum_x, sum_y, sum_w, sum_l;

    logic out_ready, adj_ready, snap_ready, take;

    assign out_ready  = !out_valid_reg || m_ready;
    assign adj_ready  = !adj_valid_reg || out_ready;
    assign snap_ready = !snap_valid_reg || adj_ready;
    assign pop        = q_stat.rd_valid && snap_ready;
    assign take       = pop;

    always_comb begin
        smin_next   = (anchor.sum_lo < smin_reg) ? anchor.sum_lo : smin_reg;
        dmin_next   = (anchor.diff_lo < dmin_reg) ? anchor.diff_lo : dmin_reg;
        dmax_next   = (anchor.diff_hi > dmax_reg) ? anchor.diff_hi : dmax_reg;
        smax_next   = (anchor.sum_hi > smax_reg) ? anchor.sum_hi : smax_reg;
        contig_next = open_reg ? contig_reg : anchor.contig;
        weight_add  = {1'b0, weight_reg}
                    + {{(WEIGHT_SUM_BITS+1-FIELD_BITS){1'b0}}, anchor.weight};
        weight_next = weight_add[WEIGHT_SUM_BITS] ? {WEIGHT_SUM_BITS{1'b1}}
                                                  : weight_add[WEIGHT_SUM_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smin_reg   <= BORDER_MAX;
            dmin_reg   <= BORDER_MAX;
            dmax_reg   <= BORDER_MIN;
            smax_reg   <= BORDER_MIN;
            weight_reg <= '0;
            contig_reg <= '0;
            open_reg   <= 1'b0;
        end else if (take) begin
            if (anchor.last) begin
                smin_reg   <= BORDER_MAX;
                dmin_reg   <= BORDER_MAX;
                dmax_reg   <= BORDER_MIN;
                smax_reg   <= BORDER_MIN;
                weight_reg <= '0;
                contig_reg <= '0;
                open_reg   <= 1'b0;
            end else begin
                smin_reg   <= smin_next;
                dmin_reg   <= dmin_next;
                dmax_reg   <= dmax_next;
                smax_reg   <= smax_next;
                weight_reg <= weight_next;
                contig_reg <= contig_next;
                open_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready) begin
            snap_smin_reg   <= smin_next;
            snap_dmin_reg   <= dmin_next;
            snap_dmax_reg   <= dmax_next;
            snap_smax_reg   <= smax_next;
            snap_weight_reg <= weight_next;
            snap_contig_reg <= contig_next;
        end
    end

    // parity of each span from the low bits; the lowered smin has dmin's parity
    assign odd_lo  = snap_smin_reg[0] ^ snap_dmin_reg[0];
    assign odd_dhi = snap_dmax_reg[0] ^ snap_dmin_reg[0];
    assign odd_shi = snap_smax_reg[0] ^ snap_dmin_reg[0];

    always_ff @(posedge aclk) begin
        if (adj_ready) begin
            adj_sminp_reg  <= adj_t'(snap_smin_reg)
                            - $signed({{(ADJ_BITS-1){1'b0}}, odd_lo});
            adj_dmin_reg   <= adj_t'(snap_dmin_reg);
            adj_dmaxp2_reg <= adj_t'(snap_dmax_reg)
                            + $signed({{(ADJ_BITS-2){1'b0}}, 1'b1, odd_dhi});
            adj_smaxp2_reg <= adj_t'(snap_smax_reg)
                            + $signed({{(ADJ_BITS-2){1'b0}}, 1'b1, odd_shi});
            adj_weight_reg <= snap_weight_reg;
            adj_contig_reg <= snap_contig_reg;
        end
    end

    // spans are even now, so halving is a plain bit drop
    always_comb begin
        sum_x = wide_t'(adj_sminp_reg) + wide_t'(adj_dmin_reg);
        sum_y = wide_t'(adj_sminp_reg) - wide_t'(adj_dmin_reg);
        sum_w = wide_t'(adj_dmaxp2_reg) - wide_t'(adj_dmin_reg);
        sum_l = wide_t'(adj_smaxp2_reg) - wide_t'(adj_sminp_reg);
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_x_reg      <= sum_x[OUT_BITS:1];
            out_y_reg      <= sum_y[OUT_BITS:1];
            out_w_reg      <= sum_w[OUT_BITS:1];
            out_l_reg      <= sum_l[OUT_BITS:1];
            out_weight_reg <= adj_weight_reg;
            out_contig_reg <= adj_contig_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
            adj_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (snap_ready) begin
                snap_valid_reg <= take && anchor.last;
            end
            if (adj_ready) begin
                adj_valid_reg <= snap_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= adj_valid_reg;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign merged_x      = out_x_reg;
    assign merged_y      = out_y_reg;
    assign merged_width  = out_w_reg;
    assign merged_length = out_l_reg;
    assign merged_weight = out_weight_reg;
    assign merged_contig = out_contig_reg;

endmodule

@@ rtl/core/dbm_checker.sv @@
module dbm_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_ready,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [dbm_pkg::OUT_BITS-1:0]   m_merged_x,
    input  logic signed [dbm_pkg::OUT_BITS-1:0]   m_merged_y,
    input  logic [dbm_pkg::OUT_BITS-1:0]          m_merged_width,
    input  logic [dbm_pkg::OUT_BITS-1:0]          m_merged_length,
    input  logic [dbm_pkg::WEIGHT_SUM_BITS-1:0]   m_merged_weight,
    input  logic [dbm_pkg::FIELD_BITS-1:0]        m_merged_contig
);

    // a stalled result holds its payload
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_merged_x) && $stable(m_merged_y)
            && $stable(m_merged_width) && $stable(m_merged_length)
            && $stable(m_merged_weight) && $stable(m_merged_contig))
        else $error("result changed while stalled");

    // reset clears the output pipeline
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid after reset");

    // reset empties the queue, so anchors are taken right away
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("s_ready low after reset");

    // a result needs a closing anchor to pass the queue and the result stages first, so none shows right after reset
    a_no_early_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid ##1 !m_valid ##1 !m_valid ##1 !m_valid)
        else $error("result appeared too soon after reset");

endmodule

bind diagonal_band_merge_core dbm_checker u_dbm_checker (.*);

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // watchdog: cycles with no transaction on either channel before giving up
    localparam int QUIET_LIMIT   = 5000;
    // one long receiver hold-off, long enough to fill the block and drop s_ready
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 300;
    // settle time after the last result, well over the block's latency
    localparam int DRAIN_CYCLES  = 16;

    typedef logic signed [dbm_pkg::COORD_BITS-1:0] coord_t;
    typedef logic [dbm_pkg::OUT_BITS-1:0]          span_t;

    localparam coord_t COORD_MAX = {1'b0, {(dbm_pkg::COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(dbm_pkg::COORD_BITS-1){1'b0}}};
    localparam dbm_pkg::field_t FIELD_MAX = '1;

    typedef struct {
        coord_t          pos_x;
        coord_t          pos_y;
        dbm_pkg::field_t band_width;
        dbm_pkg::field_t band_length;
        dbm_pkg::field_t score_weight;
        dbm_pkg::field_t contig_id;
        logic            last_in_group;
    } anchor_txn_t;

    typedef struct {
        span_t                merged_x;
        span_t                merged_y;
        span_t                merged_width;
        span_t                merged_length;
        dbm_pkg::weight_sum_t merged_weight;
        dbm_pkg::field_t      merged_contig;
    } band_txn_t;

    logic            aclk            = 1'b0;
    logic            aresetn         = 1'b0;
    logic            s_valid         = 1'b0;
    logic            s_ready;
    coord_t          s_pos_x         = '0;
    coord_t          s_pos_y         = '0;
    dbm_pkg::field_t s_band_width    = '0;
    dbm_pkg::field_t s_band_length   = '0;
    dbm_pkg::field_t s_score_weight  = '0;
    dbm_pkg::field_t s_contig_id     = '0;
    logic            s_last_in_group = 1'b0;
    logic            m_valid;
    logic            m_ready         = 1'b0;
    logic signed [dbm_pkg::OUT_BITS-1:0] m_merged_x;
    logic signed [dbm_pkg::OUT_BITS-1:0] m_merged_y;
    span_t                               m_merged_width;
    span_t                               m_merged_length;
    dbm_pkg::weight_sum_t                m_merged_weight;
    dbm_pkg::field_t                     m_merged_contig;

    // anchors waiting to be driven, and bands the block still owes us
    anchor_txn_t anchor_q[$];
    band_txn_t   band_q[$];

    int unsigned anchors_queued = 0;
    int unsigned anchors_sent   = 0;
    int unsigned anchors_taken  = 0;
    int unsigned mismatches     = 0;

    // idle percentages per phase, changed only between phases
    int unsigned send_idle_pct  = 31;
    int unsigned recv_idle_pct  = 55;
    int unsigned hold_left      = 0;
    logic        long_hold_done = 1'b0;

    // running group state of the predictor, in rotated (sum, diff) space
    dbm_pkg::border_t     lo_sum;
    dbm_pkg::border_t     lo_diff;
    dbm_pkg::border_t     hi_diff;
    dbm_pkg::border_t     hi_sum;
    dbm_pkg::weight_sum_t weight_acc;
    dbm_pkg::field_t      group_contig;
    logic                 group_open;

    diagonal_band_merge_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_band_width    (s_band_width),
        .s_band_length   (s_band_length),
        .s_score_weight  (s_score_weight),
        .s_contig_id     (s_contig_id),
        .s_last_in_group (s_last_in_group),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_merged_x      (m_merged_x),
        .m_merged_y      (m_merged_y),
        .m_merged_width  (m_merged_width),
        .m_merged_length (m_merged_length),
        .m_merged_weight (m_merged_weight),
        .m_merged_contig (m_merged_contig)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // back to the empty-group state: lower borders at the top, upper at the bottom
    function automatic void clear_group();
        lo_sum       = dbm_pkg::BORDER_MAX;
        lo_diff      = dbm_pkg::BORDER_MAX;
        hi_diff      = dbm_pkg::BORDER_MIN;
        hi_sum       = dbm_pkg::BORDER_MIN;
        weight_acc   = '0;
        group_contig = '0;
        group_open   = 1'b0;
    endfunction

    // fold one accepted anchor into the group; a closing anchor yields a band
    task automatic absorb_anchor(input anchor_txn_t a);
        dbm_pkg::border_t                s_lo;
        dbm_pkg::border_t                d_lo;
        dbm_pkg::border_t                d_hi;
        dbm_pkg::border_t                s_hi;
        logic [dbm_pkg::WEIGHT_SUM_BITS:0] wide_weight;
        longint                          smin;
        longint                          dmin;
        longint                          dmax;
        longint                          smax;
        longint                          mx;
        band_txn_t                       band;
        s_lo = dbm_pkg::border_t'(a.pos_x) + dbm_pkg::border_t'(a.pos_y);
        d_lo = dbm_pkg::border_t'(a.pos_x) - dbm_pkg::border_t'(a.pos_y);
        // zero width or length gives a -2 term, kept as is
        d_hi = d_lo + 2 * (dbm_pkg::border_t'(a.band_width) - 1);
        s_hi = s_lo + 2 * (dbm_pkg::border_t'(a.band_length) - 1);
        if (!group_open) begin
            group_contig = a.contig_id;
            group_open   = 1'b1;
        end
        if (s_lo < lo_sum)  lo_sum  = s_lo;
        if (d_lo < lo_diff) lo_diff = d_lo;
        if (d_hi > hi_diff) hi_diff = d_hi;
        if (s_hi > hi_sum)  hi_sum  = s_hi;
        // saturating weight sum
        wide_weight = {1'b0, weight_acc} + a.score_weight;
        weight_acc  = wide_weight[dbm_pkg::WEIGHT_SUM_BITS] ? '1
                                                           : wide_weight[dbm_pkg::WEIGHT_SUM_BITS-1:0];
        if (a.last_in_group) begin
            smin = lo_sum;
            dmin = lo_diff;
            dmax = hi_diff;
            smax = hi_sum;
            // round odd sums outward so every halving is exact
            if ((smin + dmin) % 2 != 0) smin = smin - 1;
            mx = (smin + dmin) / 2;
            if ((dmax - dmin) % 2 != 0) dmax = dmax + 1;
            if ((smax - smin) % 2 != 0) smax = smax + 1;
            band.merged_x      = span_t'(mx);
            band.merged_y      = span_t'(smin - mx);
            band.merged_width  = span_t'((dmax - dmin) / 2 + 1);
            band.merged_length = span_t'((smax - smin) / 2 + 1);
            band.merged_weight = weight_acc;
            band.merged_contig = group_contig;
            band_q.push_back(band);
            clear_group();
        end
    endtask

    task automatic check_field(input string name, input span_t want, input span_t got);
        if (got !== want) begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_anchor(input anchor_txn_t a);
        anchor_q.push_back(a);
        anchors_queued++;
    endtask

    task automatic queue_one(input coord_t x, input coord_t y,
                             input dbm_pkg::field_t w, input dbm_pkg::field_t l,
                             input dbm_pkg::field_t wt, input dbm_pkg::field_t cn,
                             input logic last);
        anchor_txn_t a;
        a.pos_x         = x;
        a.pos_y         = y;
        a.band_width    = w;
        a.band_length   = l;
        a.score_weight  = wt;
        a.contig_id     = cn;
        a.last_in_group = last;
        push_anchor(a);
    endtask

    // band sizes: corners (0, 1, max), short bands and anything in range
    function automatic dbm_pkg::field_t pick_size();
        case ($urandom_range(7))
            0: return '0;
            1: return 16'd1;
            2: return FIELD_MAX;
            3: return dbm_pkg::field_t'($urandom_range(16, 1));
            default: return dbm_pkg::field_t'($urandom_range(65535));
        endcase
    endfunction

    // whole groups until at least n_target anchors are queued; most groups are
    // clustered around one spot so the min/max tracking sees close contenders
    task automatic queue_groups(input int unsigned n_target);
        int unsigned made;
        int unsigned group_len;
        logic        clustered;
        coord_t      base_x;
        coord_t      base_y;
        anchor_txn_t a;
        made = 0;
        while (made < n_target) begin
            group_len = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
            clustered = ($urandom_range(3) != 0);
            base_x    = $urandom;
            base_y    = $urandom;
            for (int unsigned i = 0; i < group_len; i++) begin
                if (clustered) begin
                    a.pos_x = base_x + $urandom_range(4000) - 2000;
                    a.pos_y = base_y + $urandom_range(4000) - 2000;
                end else begin
                    a.pos_x = $urandom;
                    a.pos_y = $urandom;
                end
                a.band_width    = pick_size();
                a.band_length   = pick_size();
                a.score_weight  = dbm_pkg::field_t'($urandom_range(65535));
                a.contig_id     = dbm_pkg::field_t'($urandom_range(65535));
                a.last_in_group = (i == group_len - 1);
                push_anchor(a);
            end
            made += group_len;
        end
    endtask

    // hold the sender until every anchor is in and every band is out
    task automatic wait_all_done();
        while (anchors_taken != anchors_queued || band_q.size() != 0) @(negedge aclk);
    endtask

    // driver: next anchor on the falling edge once the current one has gone
    always @(negedge aclk) begin
        anchor_txn_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || anchors_taken == anchors_sent) begin
            if (anchor_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = anchor_q.pop_front();
                anchors_sent++;
                s_pos_x         <= nxt.pos_x;
                s_pos_y         <= nxt.pos_y;
                s_band_width    <= nxt.band_width;
                s_band_length   <= nxt.band_length;
                s_score_weight  <= nxt.score_weight;
                s_contig_id     <= nxt.contig_id;
                s_last_in_group <= nxt.last_in_group;
                s_valid         <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off that fills the queue
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && anchors_taken >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            m_ready       <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: results checked against the oldest band, anchors fed to the predictor
    always @(posedge aclk) begin
        band_txn_t   want;
        anchor_txn_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (band_q.size() == 0) begin
                    $error("merged band transaction with no group closed");
                    mismatches++;
                end else begin
                    want = band_q.pop_front();
                    check_field("merged_x", want.merged_x, m_merged_x);
                    check_field("merged_y", want.merged_y, m_merged_y);
                    check_field("merged_width", want.merged_width, m_merged_width);
                    check_field("merged_length", want.merged_length, m_merged_length);
                    check_field("merged_weight", span_t'(want.merged_weight),
                                span_t'(m_merged_weight));
                    check_field("merged_contig", span_t'(want.merged_contig),
                                span_t'(m_merged_contig));
                end
            end
            if (s_valid && s_ready) begin
                seen.pos_x         = s_pos_x;
                seen.pos_y         = s_pos_y;
                seen.band_width    = s_band_width;
                seen.band_length   = s_band_length;
                seen.score_weight  = s_score_weight;
                seen.contig_id     = s_contig_id;
                seen.last_in_group = s_last_in_group;
                absorb_anchor(seen);
                anchors_taken++;
            end
        end else begin
            clear_group();
        end
    end

    // watchdog: too long with no transaction on either side
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("[diagonal_band_merge_core] ERROR");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        @(posedge aclk);

        // directed: lone anchors at the coordinate and size corners
        queue_one(0, 0, 16'd1, 16'd1, 16'd0, 16'd0, 1'b1);
        queue_one(COORD_MAX, COORD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, 1'b1);
        queue_one(COORD_MIN, COORD_MIN, 16'd1, 16'd1, 16'd0, 16'd0, 1'b1);
        queue_one(COORD_MAX, COORD_MIN, FIELD_MAX, 16'd1, 16'd1, 16'd1, 1'b1);
        queue_one(COORD_MIN, COORD_MAX, 16'd1, FIELD_MAX, 16'd2, 16'd2, 1'b1);
        // zero width and length, which the ports allow
        queue_one(5, -7, 16'd0, 16'd0, 16'd3, 16'd77, 1'b1);
        queue_one(-1, -1, 16'd0, FIELD_MAX, 16'd4, 16'd78, 1'b1);
        // mixed parity of sum and diff borders forces the outward rounding;
        // the contig of the first anchor must survive
        queue_one(1, 0, 16'd1, 16'd1, 16'd10, 16'd500, 1'b0);
        queue_one(1, 1, 16'd2, 16'd1, 16'd20, 16'd600, 1'b0);
        queue_one(4, 2, 16'd3, 16'd3, 16'd30, 16'd700, 1'b1);
        // one group spanning both coordinate extremes
        queue_one(COORD_MIN, COORD_MAX, 16'd1, 16'd1, 16'd5, 16'd11, 1'b0);
        queue_one(COORD_MAX, COORD_MIN, 16'd1, 16'd1, 16'd6, 16'd12, 1'b0);
        queue_one(0, 0, FIELD_MAX, FIELD_MAX, FIELD_MAX, 16'd13, 1'b1);
        queue_one(100, 200, 16'd7, 16'd9, FIELD_MAX, 16'd9, 1'b0);
        queue_one(100, 200, 16'd7, 16'd9, FIELD_MAX, 16'd10, 1'b1);
        // alternating bit patterns on every field
        queue_one(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
        queue_one(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1);

        // phase one: sender idles a third of the time, receiver over half
        queue_groups(480);
        wait_all_done();

        // phase two: the other way round
        send_idle_pct = 55;
        recv_idle_pct = 31;
        @(posedge aclk);
        queue_groups(480);
        wait_all_done();

        // phase three: full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        queue_groups(470);
        wait_all_done();

        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && band_q.size() == 0) begin
            $display("[diagonal_band_merge_core] OK");
        end else begin
            $display("[diagonal_band_merge_core] ERROR");
        end
        $finish;
    end

endmodule
